@@ design/tsm_pkg.sv @@
package tsm_pkg;

  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [7:0]  EndMarkerReset    = 8'd255;
  localparam logic [7:0]  SectorMarkerReset = 8'd254;
  localparam logic [7:0]  SkipMarkerReset   = 8'd253;
  localparam logic [15:0] Interval0Reset    = 16'd7;
  localparam logic [15:0] Interval1Reset    = 16'd7;
  localparam logic [15:0] Interval2Reset    = 16'd11;
  localparam logic [15:0] Interval3Reset    = 16'd15;

  typedef enum logic [2:0] {
    RegEndMarker    = 3'd0,
    RegSectorMarker = 3'd1,
    RegSkipMarker   = 3'd2,
    RegInterval0    = 3'd3,
    RegInterval1    = 3'd4,
    RegInterval2    = 3'd5,
    RegInterval3    = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]       end_code;
    logic [7:0]       sector_code;
    logic [7:0]       skip_code;
    logic [3:0][15:0] interval;
  } cfg_t;

  // One data byte waiting for expansion, with the header seen when it arrived.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] side;
    logic [7:0] track;
    logic [7:0] sector;
  } entry_t;

endpackage

@@ design/tsm_regs.sv @@
module tsm_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [tsm_pkg::ApbAddrW-1:0] paddr_i,
  input  logic [tsm_pkg::ApbDataW-1:0] pwdata_i,
  output logic [tsm_pkg::ApbDataW-1:0] prdata_o,
  output logic                         pready_o,
  output tsm_pkg::cfg_t                cfg_o
);
  import tsm_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign idx      = paddr_i[4:2];
  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.end_code    <= EndMarkerReset;
      cfg_q.sector_code <= SectorMarkerReset;
      cfg_q.skip_code   <= SkipMarkerReset;
      cfg_q.interval[0] <= Interval0Reset;
      cfg_q.interval[1] <= Interval1Reset;
      cfg_q.interval[2] <= Interval2Reset;
      cfg_q.interval[3] <= Interval3Reset;
    end else if (wr_en) begin
      unique case (idx)
        RegEndMarker:    cfg_q.end_code    <= pwdata_i[7:0];
        RegSectorMarker: cfg_q.sector_code <= pwdata_i[7:0];
        RegSkipMarker:   cfg_q.skip_code   <= pwdata_i[7:0];
        RegInterval0:    cfg_q.interval[0] <= pwdata_i[15:0];
        RegInterval1:    cfg_q.interval[1] <= pwdata_i[15:0];
        RegInterval2:    cfg_q.interval[2] <= pwdata_i[15:0];
        RegInterval3:    cfg_q.interval[3] <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegEndMarker:    prdata_o = {24'd0, cfg_q.end_code};
      RegSectorMarker: prdata_o = {24'd0, cfg_q.sector_code};
      RegSkipMarker:   prdata_o = {24'd0, cfg_q.skip_code};
      RegInterval0:    prdata_o = {16'd0, cfg_q.interval[0]};
      RegInterval1:    prdata_o = {16'd0, cfg_q.interval[1]};
      RegInterval2:    prdata_o = {16'd0, cfg_q.interval[2]};
      RegInterval3:    prdata_o = {16'd0, cfg_q.interval[3]};
      default:         prdata_o = '0;
    endcase
  end

endmodule

@@ design/tsm_front.sv @@
module tsm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic            req_type_i,
  input  logic [7:0]      track_byte_i,
  input  logic            buffer_last_i,
  input  tsm_pkg::cfg_t   cfg_i,
  output logic            enq_o,
  output tsm_pkg::entry_t entry_o
);
  import tsm_pkg::*;

  typedef enum logic [1:0] {
    PhNone   = 2'd0,
    PhSide   = 2'd1,
    PhTrack  = 2'd2,
    PhSector = 2'd3
  } phase_e;

  phase_e     phase_q;
  logic       stopped_q;
  logic [7:0] side_q, track_q, sector_q;
  logic       is_end, is_drop, is_sector, live;

  assign live      = accept_i & ~req_type_i & ~stopped_q & (phase_q == PhNone);
  assign is_end    = buffer_last_i | (track_byte_i == cfg_i.end_code);
  assign is_drop   = (track_byte_i == 8'd0) | (track_byte_i == cfg_i.skip_code);
  assign is_sector = track_byte_i == cfg_i.sector_code;

  assign enq_o          = live & ~is_end & ~is_drop & ~is_sector;
  assign entry_o.data   = track_byte_i;
  assign entry_o.side   = side_q;
  assign entry_o.track  = track_q;
  assign entry_o.sector = sector_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhNone;
      stopped_q <= 1'b0;
      side_q    <= '0;
      track_q   <= '0;
      sector_q  <= '0;
    end else if (accept_i) begin
      if (req_type_i) begin
        stopped_q <= 1'b0;
        phase_q   <= PhNone;
      end else if (!stopped_q) begin
        unique case (phase_q)
          PhSide: begin
            side_q    <= track_byte_i;
            phase_q   <= PhTrack;
            stopped_q <= buffer_last_i;
          end
          PhTrack: begin
            track_q   <= track_byte_i;
            phase_q   <= PhSector;
            stopped_q <= buffer_last_i;
          end
          PhSector: begin
            sector_q  <= track_byte_i;
            phase_q   <= PhNone;
            stopped_q <= buffer_last_i;
          end
          PhNone: begin
            if (is_end) begin
              stopped_q <= 1'b1;
            end else if (!is_drop && is_sector) begin
              phase_q <= PhSide;
            end
          end
          default: phase_q <= PhNone;
        endcase
      end
    end
  end

endmodule

@@ design/tsm_fifo.sv @@
module tsm_fifo #(
  parameter int unsigned Depth = tsm_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  tsm_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            rd_i,
  output logic            valid_o,
  output tsm_pkg::entry_t rdata_o
);
  import tsm_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_wr, do_rd;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rptr_q];
  assign do_wr   = wr_i & ~full_o;
  assign do_rd   = rd_i & valid_o;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= ptr_next(wptr_q);
      end
      if (do_rd) begin
        rptr_q <= ptr_next(rptr_q);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

@@ design/tsm_back.sv @@
module tsm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tsm_pkg::cfg_t   cfg_i,
  input  logic            head_valid_i,
  input  tsm_pkg::entry_t head_i,
  output logic            deq_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [15:0]     interval_value_o,
  output logic            group_last_o,
  output logic [7:0]      cur_side_o,
  output logic [7:0]      cur_track_o,
  output logic [7:0]      cur_sector_o
);
  import tsm_pkg::*;

  logic [1:0]  slot_q;
  logic        out_valid_q;
  logic [15:0] interval_q;
  logic        last_q;
  logic [7:0]  side_q, track_q, sector_q;
  logic [1:0]  sym;
  logic        load;

  // Most significant symbol first.
  always_comb begin
    case (slot_q)
      2'd0:    sym = head_i.data[7:6];
      2'd1:    sym = head_i.data[5:4];
      2'd2:    sym = head_i.data[3:2];
      default: sym = head_i.data[1:0];
    endcase
  end

  assign load  = head_valid_i & (~out_valid_q | pop_i);
  assign deq_o = load & (slot_q == 2'd3);

  assign empty_o          = ~out_valid_q;
  assign interval_value_o = interval_q;
  assign group_last_o     = last_q;
  assign cur_side_o       = side_q;
  assign cur_track_o      = track_q;
  assign cur_sector_o     = sector_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      slot_q      <= slot_q + 2'd1;
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      interval_q <= cfg_i.interval[sym];
      last_q     <= slot_q == 2'd3;
      side_q     <= head_i.side;
      track_q    <= head_i.track;
      sector_q   <= head_i.sector;
    end
  end

endmodule

@@ design/track_stream_to_mfm_intervals_top.sv @@
// A data byte accepted is written into the queue; the expander then loads its first interval
// into the result register, and the next three follow while pop is held.
// Throughput: one result per cycle while pop is held; each data byte gives four results, as
// the expander steps through the four symbols; other items are taken one per cycle until the queue fills.
// Reset: asynchronous, active low; clears stream state, header values and queues, and loads
// the marker and interval registers with their default codes.
module track_stream_to_mfm_intervals_top #(
  parameter int unsigned QueueDepth = tsm_pkg::QueueDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic                         req_type_i,
  input  logic [7:0]                   track_byte_i,
  input  logic                         buffer_last_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [15:0]                  interval_value_o,
  output logic                         group_last_o,
  output logic [7:0]                   cur_side_o,
  output logic [7:0]                   cur_track_o,
  output logic [7:0]                   cur_sector_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tsm_pkg::ApbAddrW-1:0] paddr,
  input  logic [tsm_pkg::ApbDataW-1:0] pwdata,
  output logic [tsm_pkg::ApbDataW-1:0] prdata,
  output logic                         pready
);
  import tsm_pkg::*;

  cfg_t   cfg;
  entry_t enq_entry, head;
  logic   enq, deq, head_valid, accept;

  assign accept = push & ~full;

  tsm_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  tsm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .req_type_i    (req_type_i),
    .track_byte_i  (track_byte_i),
    .buffer_last_i (buffer_last_i),
    .cfg_i         (cfg),
    .enq_o         (enq),
    .entry_o       (enq_entry)
  );

  tsm_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (enq),
    .wdata_i (enq_entry),
    .full_o  (full),
    .rd_i    (deq),
    .valid_o (head_valid),
    .rdata_o (head)
  );

  tsm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .head_valid_i     (head_valid),
    .head_i           (head),
    .deq_o            (deq),
    .pop_i            (pop),
    .empty_o          (empty),
    .interval_value_o (interval_value_o),
    .group_last_o     (group_last_o),
    .cur_side_o       (cur_side_o),
    .cur_track_o      (cur_track_o),
    .cur_sector_o     (cur_sector_o)
  );

endmodule

@@ design/tsm_checker.sv @@
module tsm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [15:0] interval_value_o,
  input logic        group_last_o,
  input logic [7:0]  cur_side_o,
  input logic [7:0]  cur_track_o,
  input logic [7:0]  cur_sector_o
);

  // No result may be shown while reset is applied.
  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result shown during reset");

  // Coming out of reset the queue has room.
  a_room_after_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> !full)
    else $error("full right after reset");

  // Within one byte's group the next interval follows at once with the same header.
  a_group_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !group_last_o) |=>
      (!empty && $stable(cur_side_o) && $stable(cur_track_o) && $stable(cur_sector_o)))
    else $error("byte group broken");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(interval_value_o) && $stable(group_last_o)))
    else $error("stalled result changed");

endmodule

bind track_stream_to_mfm_intervals_top tsm_checker u_tsm_checker (.*);

@@ dv/track_stream_to_mfm_intervals_top_tb.sv @@
module track_stream_to_mfm_intervals_top_tb;
  import tsm_pkg::*;

  typedef enum logic [1:0] {HdrNone, HdrSide, HdrTrack, HdrSector} hdr_phase_e;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
    logic [7:0]  side;
    logic [7:0]  track;
    logic [7:0]  sector;
  } interval_t;

  typedef struct packed {
    logic             rq;
    logic [7:0]       data;
    logic             lst;
    logic             typed;
    logic [2:0]       n;
    logic [0:3][15:0] iv;
    logic [7:0]       side;
    logic [7:0]       track;
    logic [7:0]       sector;
  } stim_row_t;

  // rq, byte, last, typed, count, intervals, side, track, sector
  localparam stim_row_t DirectedRows [25] = '{
    '{1'b0, 8'h1B, 1'b0, 1'b1, 3'd4, {16'd7, 16'd7, 16'd11, 16'd15}, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'h00, 1'b0, 1'b1, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'hFD, 1'b0, 1'b1, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'hE4, 1'b0, 1'b1, 3'd4, {16'd15, 16'd11, 16'd7, 16'd7}, 8'h00, 8'h00, 8'h00},
    // sector header whose bytes all look like markers
    '{1'b0, 8'hFE, 1'b0, 1'b1, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'hFF, 1'b0, 1'b1, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'h00, 1'b0, 1'b1, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'hFD, 1'b0, 1'b1, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'h01, 1'b0, 1'b1, 3'd4, {16'd7, 16'd7, 16'd7, 16'd7}, 8'hFF, 8'h00, 8'hFD},
    '{1'b0, 8'h80, 1'b0, 1'b0, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'h7F, 1'b0, 1'b0, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    // end marker, then a byte that must be dropped
    '{1'b0, 8'hFF, 1'b0, 1'b1, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'h55, 1'b0, 1'b1, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    '{1'b1, 8'hAA, 1'b1, 1'b1, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'hAA, 1'b0, 1'b0, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    // final buffer slot stops the stream
    '{1'b0, 8'h33, 1'b1, 1'b1, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    '{1'b1, 8'h00, 1'b0, 1'b1, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    // header cut short by the final slot
    '{1'b0, 8'hFE, 1'b0, 1'b1, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'h12, 1'b0, 1'b1, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'h34, 1'b1, 1'b1, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'h56, 1'b0, 1'b1, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    '{1'b1, 8'h00, 1'b0, 1'b1, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    // restart cancels a pending header
    '{1'b0, 8'hFE, 1'b0, 1'b1, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    '{1'b1, 8'hFF, 1'b0, 1'b1, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'h9C, 1'b0, 1'b0, 3'd0, 64'd0, 8'h00, 8'h00, 8'h00}
  };

  // Intervals are listed from symbol 3 down to symbol 0.
  localparam cfg_t ConfigPhases [3] = '{
    // all markers zero: end marker wins over zero, skip and sector
    '{8'h00, 8'h00, 8'h00, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}},
    // skip and sector share a code: skip wins
    '{8'h10, 8'h20, 8'h20, {16'h8000, 16'h0001, 16'h0000, 16'hFFFF}},
    // zero byte is also the end marker
    '{8'h00, 8'hFF, 8'h80, {16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00}}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                push;
  logic                full;
  logic                req_type_i;
  logic [7:0]          track_byte_i;
  logic                buffer_last_i;
  logic                empty;
  logic                pop;
  logic [15:0]         interval_value_o;
  logic                group_last_o;
  logic [7:0]          cur_side_o;
  logic [7:0]          cur_track_o;
  logic [7:0]          cur_sector_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  cfg_t       cfg_model;
  hdr_phase_e hdr_phase;
  logic       stopped;
  logic [7:0] hdr_side;
  logic [7:0] hdr_track;
  logic [7:0] hdr_sector;
  interval_t  pending_intervals [$];
  int         mismatches;
  int         live_items;
  int         hold_req;
  bit         tx_idle;
  bit         rx_idle;

  track_stream_to_mfm_intervals_top u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  function automatic int byte_to_intervals(input logic rq, input logic [7:0] b,
                                           input logic lst, output interval_t [0:3] res);
    logic [1:0] sym;
    res = '0;
    if (rq) begin
      stopped = 1'b0;
      hdr_phase = HdrNone;
      return 0;
    end
    if (stopped) return 0;
    if (hdr_phase != HdrNone) begin
      case (hdr_phase)
        HdrSide: begin
          hdr_side = b;
          hdr_phase = HdrTrack;
        end
        HdrTrack: begin
          hdr_track = b;
          hdr_phase = HdrSector;
        end
        default: begin
          hdr_sector = b;
          hdr_phase = HdrNone;
        end
      endcase
      if (lst) stopped = 1'b1;
      return 0;
    end
    if (lst || b == cfg_model.end_code) begin
      stopped = 1'b1;
      return 0;
    end
    if (b == 8'h00 || b == cfg_model.skip_code) return 0;
    if (b == cfg_model.sector_code) begin
      hdr_phase = HdrSide;
      return 0;
    end
    // most significant symbol first
    for (int k = 0; k < 4; k++) begin
      sym = b[7 - 2 * k -: 2];
      res[k] = '{cfg_model.interval[sym], k == 3, hdr_side, hdr_track, hdr_sector};
    end
    return 4;
  endfunction

  task automatic send_item(input stim_row_t r);
    int gap;
    int n;
    interval_t [0:3] res;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push <= 1'b1;
    req_type_i <= r.rq;
    track_byte_i <= r.data;
    buffer_last_i <= r.lst;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (!r.rq && !stopped) live_items++;
    n = byte_to_intervals(r.rq, r.data, r.lst, res);
    if (r.typed) begin
      n = r.n;
      for (int k = 0; k < 4; k++) begin
        res[k] = '{r.iv[k], k == 3, r.side, r.track, r.sector};
      end
    end
    for (int k = 0; k < n; k++) pending_intervals.push_back(res[k]);
  endtask

  task automatic put_byte(input logic rq, input logic [7:0] b, input logic lst);
    stim_row_t r;
    r = '0;
    r.rq = rq;
    r.data = b;
    r.lst = lst;
    send_item(r);
  endtask

  // Hold the input until every interval has come out, then let the queue go quiet.
  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_intervals.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [ApbDataW-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ApbAddrW'({idx, 2'b00});
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      RegEndMarker:    cfg_model.end_code = val[7:0];
      RegSectorMarker: cfg_model.sector_code = val[7:0];
      RegSkipMarker:   cfg_model.skip_code = val[7:0];
      RegInterval0:    cfg_model.interval[0] = val[15:0];
      RegInterval1:    cfg_model.interval[1] = val[15:0];
      RegInterval2:    cfg_model.interval[2] = val[15:0];
      default:         cfg_model.interval[3] = val[15:0];
    endcase
    // read it back
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== val) begin
      note_mismatch($sformatf("register %s: expected %0h, got %0h", idx.name(), val, prdata));
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(RegEndMarker, ApbDataW'(c.end_code));
    write_reg(RegSectorMarker, ApbDataW'(c.sector_code));
    write_reg(RegSkipMarker, ApbDataW'(c.skip_code));
    write_reg(RegInterval0, ApbDataW'(c.interval[0]));
    write_reg(RegInterval1, ApbDataW'(c.interval[1]));
    write_reg(RegInterval2, ApbDataW'(c.interval[2]));
    write_reg(RegInterval3, ApbDataW'(c.interval[3]));
  endtask

  // One track: restart, a run of data with headers and markers, mostly an end.
  task automatic send_track();
    int n;
    int pick;
    tx_idle = $urandom_range(0, 3) != 0;
    put_byte(1'b1, 8'($urandom), 1'($urandom));
    n = $urandom_range(2, 8);
    repeat (n) begin
      pick = $urandom_range(0, 19);
      if (pick <= 10) begin
        put_byte(1'b0, 8'($urandom), 1'b0);
      end else if (pick <= 12) begin
        put_byte(1'b0, cfg_model.sector_code, 1'b0);
        repeat (3) put_byte(1'b0, 8'($urandom), $urandom_range(0, 15) == 0);
      end else if (pick == 13) begin
        put_byte(1'b0, 8'h00, 1'b0);
      end else if (pick == 14) begin
        put_byte(1'b0, cfg_model.skip_code, 1'b0);
      end else begin
        put_byte($urandom_range(0, 7) == 0, 8'($urandom), $urandom_range(0, 3) == 0);
      end
    end
    pick = $urandom_range(0, 3);
    if (pick <= 1) begin
      put_byte(1'b0, cfg_model.end_code, 1'b0);
    end else if (pick == 2) begin
      put_byte(1'b0, 8'($urandom), 1'b1);
    end
  endtask

  initial begin : result_sink
    int stall;
    interval_t want;
    stall = 0;
    pop = 1'b0;
    rx_idle = 1'b1;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk_i);
      if (pop && !empty) begin
        if (pending_intervals.size() == 0) begin
          note_mismatch($sformatf("unexpected interval %0h", interval_value_o));
        end else begin
          want = pending_intervals.pop_front();
          if (interval_value_o !== want.value) begin
            note_mismatch($sformatf("interval_value: expected %0h, got %0h",
                                    want.value, interval_value_o));
          end
          if (group_last_o !== want.last) begin
            note_mismatch($sformatf("group_last: expected %0b, got %0b",
                                    want.last, group_last_o));
          end
          if (cur_side_o !== want.side) begin
            note_mismatch($sformatf("cur_side: expected %0h, got %0h", want.side, cur_side_o));
          end
          if (cur_track_o !== want.track) begin
            note_mismatch($sformatf("cur_track: expected %0h, got %0h",
                                    want.track, cur_track_o));
          end
          if (cur_sector_o !== want.sector) begin
            note_mismatch($sformatf("cur_sector: expected %0h, got %0h",
                                    want.sector, cur_sector_o));
          end
        end
        if ($urandom_range(0, 31) == 0) rx_idle = !rx_idle;
        stall = rx_idle ? $urandom_range(0, 11) : 0;
      end
    end
  end

  initial begin : stimulus
    int target;
    logic [7:0] b;
    cfg_t nc;
    rst_ni = 1'b0;
    push = 1'b0;
    req_type_i = 1'b0;
    track_byte_i = 8'h00;
    buffer_last_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_req = 0;
    mismatches = 0;
    live_items = 0;
    tx_idle = 1'b1;
    cfg_model = '{EndMarkerReset, SectorMarkerReset, SkipMarkerReset,
                  {Interval3Reset, Interval2Reset, Interval1Reset, Interval0Reset}};
    hdr_phase = HdrNone;
    stopped = 1'b0;
    hdr_side = 8'h00;
    hdr_track = 8'h00;
    hdr_sector = 8'h00;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[i]) send_item(DirectedRows[i]);

    for (int p = 0; p < 5; p++) begin
      settle();
      if (p < 3) begin
        nc = ConfigPhases[p];
      end else begin
        nc.end_code = 8'($urandom);
        nc.sector_code = 8'($urandom);
        nc.skip_code = 8'($urandom);
        for (int k = 0; k < 4; k++) nc.interval[k] = 16'($urandom);
      end
      apply_config(nc);
      if (p == 1) begin
        // stall the output for a long stretch while data bytes keep coming
        @(posedge clk_i);
        hold_req = 80;
        tx_idle = 1'b0;
        put_byte(1'b1, 8'h00, 1'b0);
        repeat (16) begin
          do begin
            b = 8'($urandom_range(1, 255));
          end while (b == cfg_model.end_code || b == cfg_model.sector_code ||
                     b == cfg_model.skip_code);
          put_byte(1'b0, b, 1'b0);
        end
      end
      target = live_items + 10;
      while (live_items < target) send_track();
    end

    settle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
